// File: rtl/core/ccrlt_pkg.sv
// Package for the command character run-length tokenizer.
// Holds the opcode set, character codes, result types and the byte decoder.
// No dependencies.
`timescale 1ns / 1ps

package ccrlt_pkg;

  // longest merged run; counts are capped at what repeat_count can hold
  localparam int unsigned MaxRun = 255;
  localparam logic [7:0] RunCap = (MaxRun > 255) ? 8'd255 : 8'(MaxRun);

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // character codes
  localparam logic [7:0] ChSemi = 8'h3B;  // ';'
  localparam logic [7:0] ChLf = 8'h0A;  // newline
  localparam logic [7:0] ChPlus = 8'h2B;  // '+'
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChLt = 8'h3C;  // '<'
  localparam logic [7:0] ChGt = 8'h3E;  // '>'
  localparam logic [7:0] ChCaret = 8'h5E;  // '^'
  localparam logic [7:0] ChLbrk = 8'h5B;  // '['
  localparam logic [7:0] ChRbrk = 8'h5D;  // ']'
  localparam logic [7:0] ChDot = 8'h2E;  // '.'
  localparam logic [7:0] ChAmp = 8'h26;  // '&'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChStar = 8'h2A;  // '*'
  localparam logic [7:0] ChLbrc = 8'h7B;  // '{'
  localparam logic [7:0] ChRbrc = 8'h7D;  // '}'
  localparam logic [7:0] ChAt = 8'h40;  // '@'
  localparam logic [7:0] ChLpar = 8'h28;  // '('
  localparam logic [7:0] ChRpar = 8'h29;  // ')'

  typedef enum logic [3:0] {
    OP_INITPT = 4'd0,
    OP_INCPTR = 4'd1,
    OP_DECPTR = 4'd2,
    OP_STARTL = 4'd3,
    OP_EXITLP = 4'd4,
    OP_INCVAL = 4'd5,
    OP_DECVAL = 4'd6,
    OP_PUTOUT = 4'd7,
    OP_PUTERR = 4'd8,
    OP_GETVAL = 4'd9,
    OP_DELVAL = 4'd10,
    OP_SCANLT = 4'd11,
    OP_SCANRT = 4'd12,
    OP_ENDAPP = 4'd13,
    OP_STARTC = 4'd14,
    OP_ENDCND = 4'd15
  } op_t;

  // decoded byte: hit is low for bytes that are not commands
  typedef struct packed {
    logic hit;
    op_t  op;
  } tok_t;

  // one result item
  typedef struct packed {
    op_t        op;
    logic [7:0] count;
    logic       last;
  } res_t;

  // results of one step, packed toward slot 0
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  function automatic tok_t decode_byte(input logic [7:0] b);
    tok_t t;
    t.hit = 1'b1;
    t.op = OP_INITPT;
    case (b)
      ChCaret: t.op = OP_INITPT;
      ChGt:    t.op = OP_INCPTR;
      ChLt:    t.op = OP_DECPTR;
      ChLbrk:  t.op = OP_STARTL;
      ChRbrk:  t.op = OP_EXITLP;
      ChPlus:  t.op = OP_INCVAL;
      ChMinus: t.op = OP_DECVAL;
      ChDot:   t.op = OP_PUTOUT;
      ChAmp:   t.op = OP_PUTERR;
      ChComma: t.op = OP_GETVAL;
      ChStar:  t.op = OP_DELVAL;
      ChLbrc:  t.op = OP_SCANLT;
      ChRbrc:  t.op = OP_SCANRT;
      ChAt:    t.op = OP_ENDAPP;
      ChLpar:  t.op = OP_STARTC;
      ChRpar:  t.op = OP_ENDCND;
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

  function automatic logic is_mergeable(input op_t op);
    return (op == OP_INCPTR) || (op == OP_DECPTR) ||
           (op == OP_INCVAL) || (op == OP_DECVAL);
  endfunction

endpackage

// File: rtl/core/ccrlt_step.sv
// Input register, tokenizer state and per-byte step logic.
// Depends on ccrlt_pkg; hands up to two results per byte to the result queue.
`timescale 1ns / 1ps

module ccrlt_step
  import ccrlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  input  logic       q_room,
  output logic       step_fire,
  output step_out_t  step_out
);

  // input register
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_eot;

  // tokenizer state
  logic       compress;
  logic       in_comment, in_comment_next;
  logic       run_pending, run_pending_next;
  op_t        run_op, run_op_next;
  logic [7:0] run_length, run_length_next;

  // candidate results: closed run, current byte, end of text flush
  logic       ea_v, eb_v, ec_v;
  res_t       ea, eb, ec;
  tok_t       tok;
  logic [7:0] len_inc;

  assign step_fire = a_valid && q_room;
  assign in_ready  = !a_valid || step_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= text_byte;
      a_eot  <= end_of_text;
    end
  end

  // compression enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      compress <= 1'b0;
    end else if (cfg_valid) begin
      compress <= cfg_data;
    end
  end

  // step logic
  always_comb begin
    tok = decode_byte(a_byte);
    len_inc = run_length + 8'd1;
    in_comment_next = in_comment;
    run_pending_next = run_pending;
    run_op_next = run_op;
    run_length_next = run_length;
    ea_v = 1'b0;
    eb_v = 1'b0;
    ec_v = 1'b0;
    ea = '{op: run_op, count: run_length, last: 1'b0};
    eb = '{op: tok.op, count: 8'd1, last: 1'b0};
    ec = '{op: run_op, count: run_length, last: 1'b0};

    if (in_comment) begin
      if (a_byte == ChLf) begin
        in_comment_next = 1'b0;
      end
    end else if (run_pending && compress && tok.hit && tok.op == run_op) begin
      // extend the run, close it at the cap
      if (len_inc >= RunCap) begin
        ea_v = 1'b1;
        ea.count = len_inc;
        run_pending_next = 1'b0;
        run_length_next = 8'd0;
      end else begin
        run_length_next = len_inc;
      end
    end else begin
      // close any open run first
      if (run_pending) begin
        ea_v = 1'b1;
        run_pending_next = 1'b0;
        run_length_next = 8'd0;
      end
      if (a_byte == ChSemi) begin
        in_comment_next = 1'b1;
      end else if (tok.hit) begin
        if (compress && is_mergeable(tok.op)) begin
          run_pending_next = 1'b1;
          run_op_next = tok.op;
          run_length_next = 8'd1;
        end else begin
          eb_v = 1'b1;
        end
      end
    end

    // end of text flushes a pending run and leaves comment mode
    ec.op = run_op_next;
    ec.count = run_length_next;
    if (a_eot) begin
      ec_v = run_pending_next;
      run_pending_next = 1'b0;
      run_length_next = 8'd0;
      in_comment_next = 1'b0;
    end

    // pack toward slot 0, mark the final one
    step_out.num = 2'(ea_v) + 2'(eb_v) + 2'(ec_v);
    step_out.r0 = ea_v ? ea : (eb_v ? eb : ec);
    step_out.r1 = ea_v ? (eb_v ? eb : ec) : ec;
    step_out.r0.last = (step_out.num == 2'd1);
    step_out.r1.last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment  <= 1'b0;
      run_pending <= 1'b0;
      run_op      <= OP_INITPT;
      run_length  <= 8'd0;
    end else if (step_fire) begin
      in_comment  <= in_comment_next;
      run_pending <= run_pending_next;
      run_op      <= run_op_next;
      run_length  <= run_length_next;
    end
  end

endmodule

// File: rtl/core/ccrlt_outq.sv
// Result queue: takes up to two result items per cycle, gives one per cycle while out_ready is high.
// Depends on ccrlt_pkg.
`timescale 1ns / 1ps

module ccrlt_outq
  import ccrlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  step_out_t   push_data,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);

  res_t             mem [QDepth];
  logic [QIdxW-1:0] head, tail;
  logic [QCntW-1:0] fill;
  logic             pop;
  logic [1:0]       num_in;

  assign num_in    = push ? push_data.num : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != '0);
  assign out_data  = mem[head];
  // room for the worst case of two results
  assign room      = (fill <= QCntW'(QDepth - 2));

  // entry writes
  always_ff @(posedge clk) begin
    if (num_in != 2'd0) begin
      mem[tail] <= push_data.r0;
    end
    if (num_in == 2'd2) begin
      mem[tail + QIdxW'(1)] <= push_data.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + QIdxW'(num_in);
      if (pop) begin
        head <= head + QIdxW'(1);
      end
      fill <= fill + QCntW'(num_in) - QCntW'(pop);
    end
  end

endmodule

// File: rtl/core/command_char_run_length_tokenizer_top.sv
// Command character run-length tokenizer, top level.
// Instantiates ccrlt_step and ccrlt_outq; depends on ccrlt_pkg.
`timescale 1ns / 1ps

// Takes one source byte per cycle and emits numbered opcodes for the sixteen
// command characters, skipping ';' comments and dropping other bytes. With
// compress_enable set, runs of '+', '-', '<' and '>' come out as one opcode
// with a repeat count of up to 255. Each byte passes an input register and
// the step logic, then a four-entry result queue; a byte gives zero, one or
// two results, and last_of_item marks the final one. Input is taken every
// cycle while the queue has room for two results, so a stream yielding at
// most one result per byte runs at one byte per cycle while out_ready stays
// high; a byte with two results needs a second output transfer. The
// configuration port is always ready; write it only while idle.

module command_char_run_length_tokenizer_top
  import ccrlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       compress_enable,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] opcode,
  output logic [7:0] repeat_count,
  output logic       last_of_item
);

  logic      q_room;
  logic      step_fire;
  step_out_t step_out;
  res_t      head_res;

  assign cfg_ready = 1'b1;

  // tokenizer step
  ccrlt_step u_step (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cfg_valid   (cfg_valid),
    .cfg_data    (compress_enable),
    .q_room      (q_room),
    .step_fire   (step_fire),
    .step_out    (step_out)
  );

  // result queue
  ccrlt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step_fire),
    .push_data (step_out),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head_res)
  );

  assign opcode       = head_res.op;
  assign repeat_count = head_res.count;
  assign last_of_item = head_res.last;

endmodule
